[design/cobs_serial_to_can_deframer_macros.svh]
// ----------------------------------------------------------------------------
// COBS deframer assertion macros
// Shared concurrent assertion forms for the deframer checks.
// ----------------------------------------------------------------------------
`ifndef COBS_SERIAL_TO_CAN_DEFRAMER_MACROS_SVH
`define COBS_SERIAL_TO_CAN_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define COBSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, checked outside reset.
`define COBSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

[design/cobsd_pkg.sv]
// ----------------------------------------------------------------------------
// COBS deframer package
// Phase encodings and fixed codes of the link decoder and message parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cobsd_pkg;

  // COBS code that suppresses the implicit zero before the next block
  localparam logic [7:0] CODE_NO_ZERO = 8'hff;
  localparam logic [7:0] DELIMITER    = 8'h00;

  typedef enum logic [1:0] {
    LINK_HUNT  = 2'b01,
    LINK_FRAME = 2'b10
  } link_phase_t;

  typedef enum logic [3:0] {
    PH_COUNT = 4'b0001,
    PH_ID    = 4'b0010,
    PH_LEN   = 4'b0100,
    PH_DATA  = 4'b1000
  } parse_phase_t;

endpackage

[design/cobs_serial_to_can_deframer.sv]
// ----------------------------------------------------------------------------
// COBS serial to CAN deframer
// Decodes COBS-framed serial bytes into a message stream and emits CAN frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// One serial byte is taken per clock. A byte first lands in an input register;
// the COBS decode and message parse for it run combinationally from there into
// the decoder state and the result register, and a finished frame is driven
// to the output from the result register. The input stalls only while the
// input register holds a byte and the result register holds a frame that the
// output side is stalling. Bytes are dropped until a zero delimiter; each zero
// restarts the frame and discards a partly parsed message. Messages longer than
// MAX_PAYLOAD_BYTES are consumed and dropped; payload byte k sits in bits
// 8k+7..8k with unused bytes zero.
module cobs_serial_to_can_deframer #(
  parameter int MAX_PAYLOAD_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  can_id,
  output logic [3:0]  data_length,
  output logic [63:0] payload
);

  import cobsd_pkg::*;

  localparam int GatherW = MAX_PAYLOAD_BYTES * 8;

  // input register
  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       advance;

  // decoder and parser state
  link_phase_t        link_phase, link_phase_next;
  logic [7:0]         block_remaining, block_remaining_next;
  logic [7:0]         previous_code, previous_code_next;
  parse_phase_t       parse_phase, parse_phase_next;
  logic [7:0]         messages_remaining, messages_remaining_next;
  logic [7:0]         current_id, current_id_next;
  logic [7:0]         stated_length, stated_length_next;
  logic [7:0]         bytes_gathered, bytes_gathered_next;
  logic [GatherW-1:0] payload_gather, payload_gather_next;

  // per-byte results
  logic               do_parse;
  logic               finish;
  logic               emit;
  logic [7:0]         parse_data;
  logic [GatherW-1:0] gather_fill;

  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;

  always_comb begin
    link_phase_next         = link_phase;
    block_remaining_next    = block_remaining;
    previous_code_next      = previous_code;
    parse_phase_next        = parse_phase;
    messages_remaining_next = messages_remaining;
    current_id_next         = current_id;
    stated_length_next      = stated_length;
    bytes_gathered_next     = bytes_gathered;
    payload_gather_next     = payload_gather;
    do_parse                = 1'b0;
    finish                  = 1'b0;
    emit                    = 1'b0;
    parse_data              = DELIMITER;
    gather_fill             = payload_gather;

    if (in_q_byte == DELIMITER) begin
      // open a fresh frame
      link_phase_next         = LINK_FRAME;
      block_remaining_next    = '0;
      previous_code_next      = CODE_NO_ZERO;
      parse_phase_next        = PH_COUNT;
      messages_remaining_next = '0;
      current_id_next         = '0;
      stated_length_next      = '0;
      bytes_gathered_next     = '0;
      payload_gather_next     = '0;
    end else if (link_phase == LINK_HUNT) begin
      // drop bytes until the first delimiter
    end else if (block_remaining != 8'd0) begin
      block_remaining_next = block_remaining - 8'd1;
      do_parse             = 1'b1;
      parse_data           = in_q_byte;
    end else begin
      // code byte: insert a decoded zero unless the last block was full
      previous_code_next   = in_q_byte;
      block_remaining_next = in_q_byte - 8'd1;
      if (previous_code != CODE_NO_ZERO) begin
        do_parse   = 1'b1;
        parse_data = DELIMITER;
      end
    end

    if (do_parse) begin
      unique case (parse_phase)
        PH_COUNT: begin
          messages_remaining_next = parse_data;
          parse_phase_next        = PH_ID;
        end
        PH_ID: begin
          if (messages_remaining != 8'd0) begin
            current_id_next  = parse_data;
            parse_phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          stated_length_next  = parse_data;
          bytes_gathered_next = '0;
          gather_fill         = '0;
          if (parse_data == 8'd0) begin
            finish = 1'b1;
          end else begin
            parse_phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          for (int k = 0; k < MAX_PAYLOAD_BYTES; k++) begin
            if (bytes_gathered == 8'(k)) begin
              gather_fill[8*k +: 8] = gather_fill[8*k +: 8] | parse_data;
            end
          end
          bytes_gathered_next = bytes_gathered + 8'd1;
          if (bytes_gathered_next >= stated_length) begin
            finish = 1'b1;
          end
        end
        default: begin
          parse_phase_next = PH_COUNT;
        end
      endcase
      payload_gather_next = gather_fill;

      if (finish) begin
        emit                    = (stated_length_next <= 8'(MAX_PAYLOAD_BYTES));
        messages_remaining_next = messages_remaining - 8'd1;
        parse_phase_next        = PH_ID;
        bytes_gathered_next     = '0;
        payload_gather_next     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_phase         <= LINK_HUNT;
      block_remaining    <= '0;
      previous_code      <= CODE_NO_ZERO;
      parse_phase        <= PH_COUNT;
      messages_remaining <= '0;
      current_id         <= '0;
      stated_length      <= '0;
      bytes_gathered     <= '0;
      payload_gather     <= '0;
    end else if (advance) begin
      link_phase         <= link_phase_next;
      block_remaining    <= block_remaining_next;
      previous_code      <= previous_code_next;
      parse_phase        <= parse_phase_next;
      messages_remaining <= messages_remaining_next;
      current_id         <= current_id_next;
      stated_length      <= stated_length_next;
      bytes_gathered     <= bytes_gathered_next;
      payload_gather     <= payload_gather_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // load the frame captured at message completion
  always_ff @(posedge clk) begin
    if (advance && emit) begin
      can_id      <= current_id_next;
      data_length <= stated_length_next[3:0];
      payload     <= 64'(gather_fill);
    end
  end

endmodule

[design/cobsd_checker.sv]
// ----------------------------------------------------------------------------
// COBS deframer port checker
// Watches the deframer ports for stall coupling and frame shape.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "cobs_serial_to_can_deframer_macros.svh"

module cobsd_checker #(
  parameter int MAX_PAYLOAD_BYTES = 8
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  rx_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  can_id,
  input logic [3:0]  data_length,
  input logic [63:0] payload
);

  logic frame_hold;
  logic [6:0] used_bits;

  assign frame_hold = out_valid && out_stall;
  assign used_bits  = {data_length, 3'b000};

  // input backs up only behind a stalled frame
  `COBSD_ASSERT_NOW(a_stall_cause, in_stall, frame_hold)

  // length stays within the configured payload size
  `COBSD_ASSERT_NOW(a_len_range, out_valid, 32'(data_length) <= MAX_PAYLOAD_BYTES)

  // bytes past the length are zero
  `COBSD_ASSERT_NOW(a_pad_zero, out_valid, (payload >> used_bits) == 64'd0)

  // a stalled frame holds
  `COBSD_ASSERT_NEXT(a_frame_hold, frame_hold,
    out_valid && $stable(can_id) && $stable(data_length) && $stable(payload))

endmodule

bind cobs_serial_to_can_deframer cobsd_checker #(
  .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
) u_cobsd_checker (.*);
